>>> rtl/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
// Holds the segment record, function and status codes, the controller
// states and the controller-to-datapath command and status groups.
package ffha_pkg;

	// function codes of a request
	localparam logic [1:0] FN_ALLOC  = 2'd0;
	localparam logic [1:0] FN_FREE   = 2'd1;
	localparam logic [1:0] FN_RESIZE = 2'd2;
	localparam logic [1:0] FN_NONE   = 2'd3;

	// response status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_OOM    = 2'd1;
	localparam logic [1:0] ST_NONE   = 2'd2;
	localparam logic [1:0] ST_BADPTR = 2'd3;

	// configuration register indexes
	localparam logic CFG_HEAP_BASE  = 1'b0;
	localparam logic CFG_HEAP_LIMIT = 1'b1;

	localparam logic [31:0] HEAP_LIMIT_RST = 32'd65536;
	localparam logic [32:0] ALIGN_MASK     = 33'd7;
	localparam logic [33:0] MIN_SPLIT      = 34'd16;

	// one segment table entry
	typedef struct packed {
		logic [31:0] start;
		logic [31:0] size;
		logic        free;
	} seg_t;

	// datapath micro-operations, one per cycle
	typedef enum logic [5:0] {
		OP_NONE,
		OP_LOAD,
		OP_DISP,
		OP_RD_K,
		OP_K_INC,
		OP_TAKE,
		OP_TAKE_FIT,
		OP_ST_BADPTR,
		OP_ST_NONE,
		OP_ST_OOM,
		OP_RD_IP1,
		OP_ADDR_PTR,
		OP_MOVE,
		OP_GROW,
		OP_RD_KP1,
		OP_SHIFT_DN,
		OP_CNT_DEC,
		OP_K_CNT,
		OP_RD_KM1,
		OP_SHIFT_UP,
		OP_INS,
		OP_WR_BUSY,
		OP_MV_DONE,
		OP_APP_SUM,
		OP_APPEND,
		OP_FREE,
		OP_FREE_RDN,
		OP_MERGE_N,
		OP_WR_CUR,
		OP_WR_CUR_RDP,
		OP_MERGE_P,
		OP_PUSH
	} ffha_op_t;

	// controller states
	typedef enum logic [4:0] {
		S_IDLE,
		S_DISP,
		S_FND_RD,
		S_FND_CHK,
		S_POST,
		S_GRW_CHK,
		S_RM_RD,
		S_RM_WR,
		S_FIT_RD,
		S_FIT_CHK,
		S_SPL,
		S_INS_RD,
		S_INS_WR,
		S_SPL_WR,
		S_MV,
		S_APP0,
		S_APP1,
		S_REL0,
		S_REL_CHKN,
		S_REL_WR,
		S_REL_CHKP,
		S_DONE
	} ffha_state_t;

	typedef struct packed {
		ffha_op_t op;
	} ffha_cmd_t;

	typedef struct packed {
		logic [1:0] fn;
		logic       ptr_zero;
		logic       req_zero;
		logic       moved;
		logic       k_lt_cnt;
		logic       busy_hit;
		logic       fit_hit;
		logic       rm_more;
		logic       ins_more;
		logic       ip1_lt_cnt;
		logic       i_gt0;
		logic       rd_free;
		logic       grow_ok;
		logic       need_gt_have;
		logic       split_ok;
		logic       full;
		logic       app_over;
		logic       out_busy;
	} ffha_stat_t;

endpackage

>>> rtl/ffha_if.sv
// Request and response channel interfaces of the heap allocator.
// Valid/ready handshake; no package dependency.
interface ffha_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [31:0] req_size;
	logic [31:0] ptr_addr;

	modport source (output valid, func, req_size, ptr_addr, input ready);
	modport sink (input valid, func, req_size, ptr_addr, output ready);
endinterface

interface ffha_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] addr;
	logic [1:0]  status;
	logic        copy_needed;
	logic [31:0] copy_from;
	logic [31:0] copy_len;

	modport source (output valid, addr, status, copy_needed, copy_from, copy_len,
		input ready);
	modport sink (input valid, addr, status, copy_needed, copy_from, copy_len,
		output ready);
endinterface

>>> rtl/ffha_ctrl.sv
// Sequencer of the heap allocator: walks search, shift, split, append and
// release steps and issues one datapath command per cycle. Uses ffha_pkg.
module ffha_ctrl
	import ffha_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  ffha_stat_t stat,
	output ffha_cmd_t  cmd
);

	ffha_state_t state_q, state_d;
	ffha_state_t ret_q, ret_d;

	// state and return-point registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_DISP;
			S_DISP: begin
				unique case (stat.fn)
					FN_ALLOC:  state_d = S_FIT_RD;
					FN_FREE:   state_d = stat.ptr_zero ? S_DONE : S_FND_RD;
					FN_RESIZE: state_d = stat.ptr_zero ? S_FIT_RD : S_FND_RD;
					default:   state_d = S_DONE;
				endcase
			end
			S_FND_RD:  state_d = stat.k_lt_cnt ? S_FND_CHK : S_DONE;
			S_FND_CHK: state_d = stat.busy_hit ? S_POST : S_FND_RD;
			S_POST: begin
				priority if (stat.moved || stat.fn == FN_FREE) state_d = S_REL0;
				else if (stat.req_zero) state_d = S_REL0;
				else if (stat.need_gt_have && stat.ip1_lt_cnt) state_d = S_GRW_CHK;
				else if (!stat.need_gt_have) state_d = S_DONE;
				else state_d = S_FIT_RD;
			end
			S_GRW_CHK: begin
				if (stat.grow_ok) begin
					state_d = S_RM_RD;
					ret_d   = S_SPL;
				end else begin
					state_d = S_FIT_RD;
				end
			end
			S_RM_RD:   state_d = stat.rm_more ? S_RM_WR : ret_q;
			S_RM_WR:   state_d = S_RM_RD;
			S_FIT_RD:  state_d = stat.k_lt_cnt ? S_FIT_CHK : S_APP0;
			S_FIT_CHK: state_d = stat.fit_hit ? S_SPL : S_FIT_RD;
			S_SPL:     state_d = stat.split_ok ? S_INS_RD : S_SPL_WR;
			S_INS_RD:  state_d = stat.ins_more ? S_INS_WR : S_SPL_WR;
			S_INS_WR:  state_d = S_INS_RD;
			S_SPL_WR:  state_d = stat.moved ? S_MV : S_DONE;
			S_MV:      state_d = S_FND_RD;
			S_APP0:    state_d = stat.full ? S_DONE : S_APP1;
			S_APP1: begin
				priority if (stat.app_over) state_d = S_DONE;
				else if (stat.moved) state_d = S_MV;
				else state_d = S_DONE;
			end
			S_REL0:    state_d = stat.ip1_lt_cnt ? S_REL_CHKN : S_REL_WR;
			S_REL_CHKN: begin
				if (stat.rd_free) begin
					state_d = S_RM_RD;
					ret_d   = S_REL_WR;
				end else begin
					state_d = S_REL_WR;
				end
			end
			S_REL_WR:  state_d = stat.i_gt0 ? S_REL_CHKP : S_DONE;
			S_REL_CHKP: begin
				state_d = S_DONE;
				if (stat.rd_free) begin
					state_d = S_RM_RD;
					ret_d   = S_DONE;
				end
			end
			S_DONE:    if (!stat.out_busy) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// command per state
	always_comb begin
		cmd.op   = OP_NONE;
		in_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE:    if (in_valid) cmd.op = OP_LOAD;
			S_DISP:    cmd.op = OP_DISP;
			S_FND_RD:  cmd.op = stat.k_lt_cnt ? OP_RD_K : OP_ST_BADPTR;
			S_FND_CHK: cmd.op = stat.busy_hit ? OP_TAKE : OP_K_INC;
			S_POST: begin
				priority if (stat.moved || stat.fn == FN_FREE) cmd.op = OP_NONE;
				else if (stat.req_zero) cmd.op = OP_ST_NONE;
				else if (stat.need_gt_have && stat.ip1_lt_cnt) cmd.op = OP_RD_IP1;
				else if (!stat.need_gt_have) cmd.op = OP_ADDR_PTR;
				else cmd.op = OP_MOVE;
			end
			S_GRW_CHK:  cmd.op = stat.grow_ok ? OP_GROW : OP_MOVE;
			S_RM_RD:    cmd.op = stat.rm_more ? OP_RD_KP1 : OP_CNT_DEC;
			S_RM_WR:    cmd.op = OP_SHIFT_DN;
			S_FIT_RD:   cmd.op = stat.k_lt_cnt ? OP_RD_K : OP_NONE;
			S_FIT_CHK:  cmd.op = stat.fit_hit ? OP_TAKE_FIT : OP_K_INC;
			S_SPL:      cmd.op = stat.split_ok ? OP_K_CNT : OP_NONE;
			S_INS_RD:   cmd.op = stat.ins_more ? OP_RD_KM1 : OP_INS;
			S_INS_WR:   cmd.op = OP_SHIFT_UP;
			S_SPL_WR:   cmd.op = OP_WR_BUSY;
			S_MV:       cmd.op = OP_MV_DONE;
			S_APP0:     cmd.op = stat.full ? OP_ST_OOM : OP_APP_SUM;
			S_APP1:     cmd.op = stat.app_over ? OP_ST_OOM : OP_APPEND;
			S_REL0:     cmd.op = stat.ip1_lt_cnt ? OP_FREE_RDN : OP_FREE;
			S_REL_CHKN: cmd.op = stat.rd_free ? OP_MERGE_N : OP_NONE;
			S_REL_WR:   cmd.op = stat.i_gt0 ? OP_WR_CUR_RDP : OP_WR_CUR;
			S_REL_CHKP: cmd.op = stat.rd_free ? OP_MERGE_P : OP_NONE;
			S_DONE:     cmd.op = stat.out_busy ? OP_NONE : OP_PUSH;
			default:    cmd.op = OP_NONE;
		endcase
	end

endmodule

>>> rtl/ffha_dp.sv
// Datapath of the heap allocator: segment table memory, scan index,
// request, working entry, size arithmetic and response register. Uses ffha_pkg.
module ffha_dp
	import ffha_pkg::*;
#(
	parameter int MAX_SEGMENTS = 16,
	parameter int HEADER_BYTES = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ffha_cmd_t   cmd,
	output ffha_stat_t  stat,
	input  logic [1:0]  func,
	input  logic [31:0] req_size,
	input  logic [31:0] ptr_addr,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [31:0] cfg_wdata,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [31:0] out_addr,
	output logic [1:0]  out_status,
	output logic        out_copy_needed,
	output logic [31:0] out_copy_from,
	output logic [31:0] out_copy_len
);

	localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);
	localparam logic [31:0] HDR32 = 32'(HEADER_BYTES);
	localparam logic [33:0] HDR34 = 34'(HEADER_BYTES);
	localparam logic [34:0] HDR35 = 35'(HEADER_BYTES);

	seg_t        seg_mem_q [MAX_SEGMENTS];
	seg_t        rd_q;
	seg_t        cur_q;
	logic [31:0] base_q, limit_q, top_q;
	logic [CW-1:0] cnt_q, k_q, i_q;
	logic [1:0]  fn_q;
	logic [31:0] ptr_q;
	logic        req_zero_q;
	logic [32:0] need_q;
	logic [31:0] hv_q;
	logic        mv_q;
	logic [34:0] sum_q;
	logic [33:0] end_q;
	logic [31:0] res_addr_q, res_from_q, res_len_q;
	logic [1:0]  res_status_q;
	logic        res_copy_q;
	logic        out_valid_q;
	logic [31:0] out_addr_q, out_from_q, out_len_q;
	logic [1:0]  out_status_q;
	logic        out_copy_q;

	logic [CW-1:0] k_p1, k_m1, i_p1, i_m1;
	logic [CW:0]   k_p1_w;
	logic [32:0]   req_rnd;
	logic [32:0]   used;
	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	seg_t          wr_data;

	assign k_p1   = k_q + 1'b1;
	assign k_m1   = k_q - 1'b1;
	assign i_p1   = i_q + 1'b1;
	assign i_m1   = i_q - 1'b1;
	assign k_p1_w = {1'b0, k_q} + 1'b1;
	assign used   = {1'b0, top_q} - {1'b0, base_q};

	// round request to 8 bytes, zero counts as one byte
	always_comb begin
		req_rnd = (req_size == 32'd0) ? 33'd1 : {1'b0, req_size};
		req_rnd = (req_rnd + ALIGN_MASK) & ~ALIGN_MASK;
	end

	// status toward the controller
	always_comb begin
		stat.fn           = fn_q;
		stat.ptr_zero     = (ptr_q == 32'd0);
		stat.req_zero     = req_zero_q;
		stat.moved        = mv_q;
		stat.k_lt_cnt     = (k_q < cnt_q);
		stat.busy_hit     = !rd_q.free && ((rd_q.start + HDR32) == ptr_q);
		stat.fit_hit      = rd_q.free && ({1'b0, rd_q.size} >= need_q);
		stat.rm_more      = (k_p1_w < {1'b0, cnt_q});
		stat.ins_more     = (k_q > i_p1);
		stat.ip1_lt_cnt   = (i_p1 < cnt_q);
		stat.i_gt0        = (i_q != '0);
		stat.rd_free      = rd_q.free;
		stat.grow_ok      = rd_q.free &&
			(({2'b0, cur_q.size} + HDR34 + {2'b0, rd_q.size}) >= {1'b0, need_q});
		stat.need_gt_have = (need_q > {1'b0, cur_q.size});
		stat.full         = (cnt_q >= MAX_CNT);
		stat.split_ok     = !stat.full &&
			({2'b0, cur_q.size} >= ({1'b0, need_q} + HDR34 + MIN_SPLIT));
		stat.app_over     = (sum_q > {3'b0, limit_q}) || (end_q[33:32] != 2'b00);
		stat.out_busy     = out_valid_q && !out_ready;
	end

	// table port selection
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = k_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = k_q[AW-1:0];
		wr_data = rd_q;
		unique case (cmd.op)
			OP_RD_K:  rd_en = 1'b1;
			OP_RD_IP1, OP_FREE_RDN: begin
				rd_en   = 1'b1;
				rd_addr = i_p1[AW-1:0];
			end
			OP_RD_KP1: begin
				rd_en   = 1'b1;
				rd_addr = k_p1[AW-1:0];
			end
			OP_RD_KM1: begin
				rd_en   = 1'b1;
				rd_addr = k_m1[AW-1:0];
			end
			OP_SHIFT_DN, OP_SHIFT_UP: wr_en = 1'b1;
			OP_INS: begin
				wr_en         = 1'b1;
				wr_data.start = cur_q.start + HDR32 + need_q[31:0];
				wr_data.size  = cur_q.size - need_q[31:0] - HDR32;
				wr_data.free  = 1'b1;
			end
			OP_WR_BUSY: begin
				wr_en        = 1'b1;
				wr_addr      = i_q[AW-1:0];
				wr_data      = cur_q;
				wr_data.free = 1'b0;
			end
			OP_APPEND: begin
				wr_en         = 1'b1;
				wr_addr       = cnt_q[AW-1:0];
				wr_data.start = top_q;
				wr_data.size  = need_q[31:0];
				wr_data.free  = 1'b0;
			end
			OP_WR_CUR: begin
				wr_en   = 1'b1;
				wr_addr = i_q[AW-1:0];
				wr_data = cur_q;
			end
			OP_WR_CUR_RDP: begin
				wr_en   = 1'b1;
				wr_addr = i_q[AW-1:0];
				wr_data = cur_q;
				rd_en   = 1'b1;
				rd_addr = i_m1[AW-1:0];
			end
			OP_MERGE_P: begin
				wr_en        = 1'b1;
				wr_addr      = i_m1[AW-1:0];
				wr_data.size = rd_q.size + HDR32 + cur_q.size;
				wr_data.free = 1'b1;
			end
			default: ;
		endcase
	end

	// segment table memory
	always_ff @(posedge clk) begin
		if (wr_en) seg_mem_q[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_q <= seg_mem_q[rd_addr];
	end

	// control registers: config, count, heap top, flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= 32'd0;
			limit_q     <= HEAP_LIMIT_RST;
			top_q       <= 32'd0;
			cnt_q       <= '0;
			mv_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				OP_LOAD:    mv_q <= 1'b0;
				OP_MOVE:    mv_q <= 1'b1;
				OP_CNT_DEC: cnt_q <= cnt_q - 1'b1;
				OP_INS:     cnt_q <= cnt_q + 1'b1;
				OP_APPEND: begin
					cnt_q <= cnt_q + 1'b1;
					top_q <= end_q[31:0];
				end
				default: ;
			endcase
			if (cmd.op == OP_PUSH) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			// configuration writes must arrive only while idle; the block itself does not enforce this
			if (cfg_we) begin
				if (cfg_idx == CFG_HEAP_BASE) begin
					base_q <= cfg_wdata;
					top_q  <= cfg_wdata;
					cnt_q  <= '0;
				end else begin
					limit_q <= cfg_wdata;
				end
			end
		end
	end

	// working registers and response payload
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				fn_q         <= func;
				ptr_q        <= ptr_addr;
				req_zero_q   <= (req_size == 32'd0);
				need_q       <= req_rnd;
				res_addr_q   <= 32'd0;
				res_status_q <= ST_OK;
				res_copy_q   <= 1'b0;
				res_from_q   <= 32'd0;
				res_len_q    <= 32'd0;
			end
			OP_DISP: begin
				k_q <= '0;
				if (fn_q == FN_NONE) res_status_q <= ST_NONE;
			end
			OP_K_INC:     k_q <= k_p1;
			OP_TAKE: begin
				cur_q <= rd_q;
				i_q   <= k_q;
			end
			OP_TAKE_FIT: begin
				cur_q      <= rd_q;
				i_q        <= k_q;
				res_addr_q <= rd_q.start + HDR32;
			end
			OP_ST_BADPTR: res_status_q <= ST_BADPTR;
			OP_ST_NONE:   res_status_q <= ST_NONE;
			OP_ST_OOM:    res_status_q <= ST_OOM;
			OP_ADDR_PTR:  res_addr_q <= ptr_q;
			OP_MOVE: begin
				hv_q <= cur_q.size;
				k_q  <= '0;
			end
			OP_GROW: begin
				cur_q.size <= cur_q.size + HDR32 + rd_q.size;
				k_q        <= i_p1;
				res_addr_q <= ptr_q;
			end
			OP_SHIFT_DN:  k_q <= k_p1;
			OP_K_CNT:     k_q <= cnt_q;
			OP_SHIFT_UP:  k_q <= k_m1;
			OP_INS:       cur_q.size <= need_q[31:0];
			OP_WR_BUSY:   cur_q.free <= 1'b0;
			OP_MV_DONE: begin
				res_copy_q <= 1'b1;
				res_from_q <= ptr_q;
				res_len_q  <= hv_q;
				k_q        <= '0;
			end
			OP_APP_SUM: begin
				sum_q <= {2'b0, used} + HDR35 + {2'b0, need_q};
				end_q <= {2'b0, top_q} + HDR34 + {1'b0, need_q};
			end
			OP_APPEND:    res_addr_q <= top_q + HDR32;
			OP_FREE, OP_FREE_RDN: cur_q.free <= 1'b1;
			OP_MERGE_N: begin
				cur_q.size <= cur_q.size + HDR32 + rd_q.size;
				k_q        <= i_p1;
			end
			OP_MERGE_P:   k_q <= i_q;
			OP_PUSH: begin
				out_addr_q   <= res_addr_q;
				out_status_q <= res_status_q;
				out_copy_q   <= res_copy_q;
				out_from_q   <= res_from_q;
				out_len_q    <= res_len_q;
			end
			default: ;
		endcase
	end

	assign out_valid       = out_valid_q;
	assign out_addr        = out_addr_q;
	assign out_status      = out_status_q;
	assign out_copy_needed = out_copy_q;
	assign out_copy_from   = out_from_q;
	assign out_copy_len    = out_len_q;

endmodule

>>> rtl/first_fit_heap_allocator_core.sv
// First-fit heap allocator with coalescing. Requests (allocate, release,
// resize) are taken one at a time; each returns one response held in an
// output register, so the next request is accepted while a response waits.
// Run time is set by the segment table: by the segments visited in a search
// and the entries moved when the table is shifted for a split or a merge; a
// resize that moves searches the table three times (old segment, free segment,
// old segment again). The worst case is a resize that moves on a nearly full
// table and merges both neighbors. A stalled response adds its wait.
// Depends on ffha_pkg, ffha_if, ffha_ctrl and ffha_dp.
module first_fit_heap_allocator_core
	import ffha_pkg::*;
#(
	parameter int MAX_SEGMENTS = 16,
	parameter int HEADER_BYTES = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	ffha_req_if.sink    req,
	ffha_rsp_if.source  rsp,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [31:0] cfg_wdata
);

	ffha_cmd_t  cmd;
	ffha_stat_t stat;

	// sequencer
	ffha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// table and arithmetic
	ffha_dp #(
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.HEADER_BYTES (HEADER_BYTES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.func            (req.func),
		.req_size        (req.req_size),
		.ptr_addr        (req.ptr_addr),
		.cfg_we          (cfg_we),
		.cfg_idx         (cfg_idx),
		.cfg_wdata       (cfg_wdata),
		.out_ready       (rsp.ready),
		.out_valid       (rsp.valid),
		.out_addr        (rsp.addr),
		.out_status      (rsp.status),
		.out_copy_needed (rsp.copy_needed),
		.out_copy_from   (rsp.copy_from),
		.out_copy_len    (rsp.copy_len)
	);

	// an accepted request keeps the block busy on the next cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while previous one in flight");

	// table growth only with room left
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_APPEND || cmd.op == OP_INS) |-> !stat.full)
		else $error("segment table grown past its depth");

	// a copy is only reported with a successful move
	a_copy_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.copy_needed |-> rsp.status == ST_OK)
		else $error("copy reported on failed response");

	// a response is only loaded when the output register is free
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_PUSH |-> !rsp.valid || rsp.ready)
		else $error("response overwritten before taken");

endmodule

>>> bench/tb.sv
// Self-checking bench for first_fit_heap_allocator_core: random and directed
// allocate/release/resize requests checked against an in-bench heap table model.
// Depends on ffha_pkg, ffha_if and the allocator RTL.
module tb;
	import ffha_pkg::*;

	localparam int NSEG = 16;
	localparam int HDR = 24;
	localparam int TAIL_CYCLES = 200;
	localparam longint CYCLE_LIMIT = 1500000;

	typedef struct packed {
		logic [31:0] addr;
		logic [1:0]  status;
		logic        copy_needed;
		logic [31:0] copy_from;
		logic [31:0] copy_len;
	} grant_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_idx;
	logic [31:0] cfg_wdata;

	ffha_req_if req ();
	ffha_rsp_if rsp ();

	first_fit_heap_allocator_core DUT (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	// model state
	logic [31:0] m_base, m_limit, m_top;
	logic [31:0] m_start [NSEG];
	logic [31:0] m_size [NSEG];
	bit          m_free [NSEG];
	int          m_cnt;
	logic [31:0] live_ptrs [$];

	grant_t expected_grants [$];
	int  mismatches;
	bit  failed;
	longint cycles;
	bit  burst;

	always begin
		clk = 1'b0; #10;
		clk = 1'b1; #10;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ---------------- heap table model ----------------
	function automatic longint round_up8(logic [31:0] r);
		longint v;
		v = (r == 0) ? 1 : longint'(r);
		return (v + 7) & ~longint'(7);
	endfunction

	function automatic void tbl_insert(int pos, logic [31:0] s, logic [31:0] z, bit f);
		for (int k = m_cnt; k > pos; k--) begin
			m_start[k] = m_start[k-1]; m_size[k] = m_size[k-1]; m_free[k] = m_free[k-1];
		end
		m_start[pos] = s; m_size[pos] = z; m_free[pos] = f;
		m_cnt++;
	endfunction

	function automatic void tbl_remove(int pos);
		for (int k = pos; k + 1 < m_cnt; k++) begin
			m_start[k] = m_start[k+1]; m_size[k] = m_size[k+1]; m_free[k] = m_free[k+1];
		end
		m_cnt--;
	endfunction

	function automatic void split_seg(int i, longint need);
		longint have;
		have = m_size[i];
		if (have >= need + HDR + 16 && m_cnt < NSEG) begin
			tbl_insert(i + 1, 32'(longint'(m_start[i]) + HDR + need),
				32'(have - need - HDR), 1'b1);
			m_size[i] = 32'(need);
		end
	endfunction

	function automatic int busy_index(logic [31:0] p);
		for (int i = 0; i < m_cnt; i++)
			if (!m_free[i] && 32'(longint'(m_start[i]) + HDR) == p) return i;
		return -1;
	endfunction

	function automatic logic [1:0] grant_block(longint need, output logic [31:0] a);
		longint used, e;
		a = '0;
		for (int i = 0; i < m_cnt; i++) begin
			if (m_free[i] && longint'(m_size[i]) >= need) begin
				split_seg(i, need);
				m_free[i] = 1'b0;
				a = 32'(longint'(m_start[i]) + HDR);
				return ST_OK;
			end
		end
		if (m_cnt >= NSEG) return ST_OOM;
		used = longint'(m_top) - longint'(m_base);
		if (used + HDR + need > longint'(m_limit)) return ST_OOM;
		e = longint'(m_top) + HDR + need;
		if (e > 64'hFFFF_FFFF) return ST_OOM;
		tbl_insert(m_cnt, m_top, 32'(need), 1'b0);
		a = 32'(longint'(m_top) + HDR);
		m_top = 32'(e);
		return ST_OK;
	endfunction

	function automatic void release_seg(int i);
		m_free[i] = 1'b1;
		if (i + 1 < m_cnt && m_free[i+1]) begin
			m_size[i] = m_size[i] + HDR + m_size[i+1];
			tbl_remove(i + 1);
		end
		if (i > 0 && m_free[i-1]) begin
			m_size[i-1] = m_size[i-1] + HDR + m_size[i];
			tbl_remove(i);
		end
	endfunction

	function automatic grant_t predict_grant(logic [1:0] fn, logic [31:0] rq, logic [31:0] p);
		grant_t g;
		int i;
		longint need, have;
		g = '0;
		case (fn)
			FN_ALLOC: g.status = grant_block(round_up8(rq), g.addr);
			FN_FREE: if (p != 0) begin
				i = busy_index(p);
				if (i < 0) g.status = ST_BADPTR;
				else release_seg(i);
			end
			FN_RESIZE: begin
				i = (p == 0) ? -1 : busy_index(p);
				if (p == 0) g.status = grant_block(round_up8(rq), g.addr);
				else if (i < 0) g.status = ST_BADPTR;
				else if (rq == 0) begin
					release_seg(i);
					g.status = ST_NONE;
				end else begin
					need = round_up8(rq);
					have = m_size[i];
					if (need > have && i + 1 < m_cnt && m_free[i+1] &&
						have + HDR + m_size[i+1] >= need) begin
						m_size[i] = 32'(have + HDR + m_size[i+1]);
						tbl_remove(i + 1);
						split_seg(i, need);
						g.addr = p;
					end else if (have >= need) begin
						g.addr = p;
					end else begin
						g.status = grant_block(need, g.addr);
						if (g.status == ST_OK) begin
							g.copy_needed = 1'b1;
							g.copy_from = p;
							g.copy_len = 32'(have);
							i = busy_index(p);
							if (i >= 0) release_seg(i);
						end
					end
				end
			end
			default: g.status = ST_NONE;
		endcase
		return g;
	endfunction

	// ---------------- driving ----------------
	task automatic pause_sender();
		int n;
		if (burst) return;
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
		repeat (n) @(posedge clk);
	endtask

	task automatic send_request(logic [1:0] fn, logic [31:0] rq, logic [31:0] p);
		grant_t g;
		pause_sender();
		req.valid <= 1'b1;
		req.func <= fn;
		req.req_size <= rq;
		req.ptr_addr <= p;
		do @(posedge clk); while (!req.ready);
		g = predict_grant(fn, rq, p);
		expected_grants.push_back(g);
		if (g.status == ST_OK && g.addr != 0 && !(fn == FN_RESIZE && g.addr == p))
			live_ptrs.push_back(g.addr);
		req.valid <= 1'b0;
		// the block stays busy after accepting a request, so valid is dropped before the next one
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (expected_grants.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] v);
		wait_drained();
		cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_HEAP_BASE) begin
			m_base = v; m_top = v; m_cnt = 0;
			live_ptrs.delete();
		end else m_limit = v;
	endtask

	// response stall and check
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (burst) rsp.ready <= 1'b1;
			else rsp.ready <= ($urandom_range(0, 29) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
			if (rsp.valid && rsp.ready) begin
				if (expected_grants.size() == 0) begin
					failed = 1;
					mismatches++;
					if (mismatches <= 10) $display("unexpected response addr=%h", rsp.addr);
				end else begin
					grant_t e;
					e = expected_grants.pop_front();
					if (e.addr !== rsp.addr || e.status !== rsp.status ||
						e.copy_needed !== rsp.copy_needed || e.copy_from !== rsp.copy_from ||
						e.copy_len !== rsp.copy_len) begin
						failed = 1;
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch exp addr=%h st=%0d cp=%b from=%h len=%h got addr=%h st=%0d cp=%b from=%h len=%h",
								e.addr, e.status, e.copy_needed, e.copy_from, e.copy_len,
								rsp.addr, rsp.status, rsp.copy_needed, rsp.copy_from, rsp.copy_len);
					end
				end
			end
		end
	end

	function automatic logic [31:0] pick_ptr();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 0;
		if (r == 1 || live_ptrs.size() == 0) return $urandom;
		return live_ptrs[$urandom_range(0, live_ptrs.size() - 1)];
	endfunction

	function automatic logic [31:0] pick_size();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return $urandom;
			2: return $urandom_range(200, 3000);
			default: return $urandom_range(1, 160);
		endcase
	endfunction

	// ---------------- tests ----------------
	task automatic test_directed();
		logic [31:0] a;
		send_request(FN_FREE, 0, 0);
		send_request(FN_FREE, 0, 32'h1234);
		send_request(FN_ALLOC, 0, 0);
		send_request(FN_ALLOC, 32'hFFFF_FFFF, 0);
		send_request(FN_ALLOC, 32'hFFFF_FFF9, 0);
		send_request(FN_ALLOC, 100, 0);
		send_request(FN_ALLOC, 17, 0);
		a = HDR + 8;
		send_request(FN_FREE, 0, a);
		send_request(FN_FREE, 0, a);
		send_request(FN_ALLOC, 1, 0);
		send_request(FN_RESIZE, 8, 0);
		send_request(FN_RESIZE, 200, a);
		send_request(FN_RESIZE, 4, a);
		send_request(FN_RESIZE, 0, a);
		send_request(FN_RESIZE, 50, 32'hFFFF_FFFF);
		send_request(FN_RESIZE, 70000, HDR + 8 + HDR + 104);
		send_request(FN_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(FN_ALLOC, 65536, 0);
		// fill the table
		for (int k = 0; k < 18; k++) send_request(FN_ALLOC, 8, 0);
	endtask

	task automatic test_random(int n);
		int r;
		for (int k = 0; k < n; k++) begin
			if (k % 200 == 0) burst = ($urandom_range(0, 2) == 0);
			r = $urandom_range(0, 99);
			if (r < 40) send_request(FN_ALLOC, pick_size(), 0);
			else if (r < 70) send_request(FN_FREE, 0, pick_ptr());
			else if (r < 97) send_request(FN_RESIZE, pick_size(), pick_ptr());
			else send_request(FN_NONE, $urandom, $urandom);
		end
		burst = 0;
	endtask

	task automatic test_config_extremes();
		write_reg(CFG_HEAP_LIMIT, 0);
		test_random(40);
		write_reg(CFG_HEAP_BASE, 32'hFFFF_F000);
		write_reg(CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
		test_random(150);
		write_reg(CFG_HEAP_BASE, 32'h0001_0000);
		write_reg(CFG_HEAP_LIMIT, 1024);
		test_random(200);
		write_reg(CFG_HEAP_BASE, 32'hFFFF_FFFF);
		test_random(40);
		write_reg(CFG_HEAP_BASE, 0);
		write_reg(CFG_HEAP_LIMIT, 8192);
		test_random(150);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_idx = 1'b0; cfg_wdata = '0;
		req.valid = 1'b0; req.func = '0; req.req_size = '0; req.ptr_addr = '0;
		m_base = 0; m_limit = 65536; m_top = 0; m_cnt = 0;
		mismatches = 0; failed = 0; cycles = 0; burst = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		write_reg(CFG_HEAP_BASE, 32'h0000_1000);
		test_random(700);
		test_config_extremes();
		wait_drained();
		if (!failed) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end
endmodule
